/* rtl/dmc_pkg.sv */
// Package for the delta-modulation sample channel: item kinds, register
// indexes, rate period tables and the result word layout.
// No dependencies.
package dmc_pkg;

    // Widths of the configuration port
    localparam int DMC_CFG_IDX_W  = 3;
    localparam int DMC_CFG_DATA_W = 8;

    // Width of the result word on the master side
    localparam int DMC_OUT_W      = 26;
    localparam int DMC_OUT_BYTES_W = 32;

    // Address handling
    localparam logic [15:0] DMC_ADDR_BASE = 16'hC000;
    localparam logic [15:0] DMC_ADDR_WRAP = 16'h8000;
    localparam logic [15:0] DMC_ADDR_TOP  = 16'hFFFF;

    // Item kinds carried in the slave tuser
    typedef enum logic [1:0] {
        DMC_FUNC_TICK   = 2'd0,
        DMC_FUNC_FETCH  = 2'd1,
        DMC_FUNC_LOAD   = 2'd2,
        DMC_FUNC_ENABLE = 2'd3
    } dmc_func_t;

    // Configuration register indexes
    typedef enum logic [DMC_CFG_IDX_W-1:0] {
        DMC_REG_RATE   = 3'd0,
        DMC_REG_PAL    = 3'd1,
        DMC_REG_LOOP   = 3'd2,
        DMC_REG_IRQEN  = 3'd3,
        DMC_REG_START  = 3'd4,
        DMC_REG_LENGTH = 3'd5
    } dmc_reg_t;

    // Bit periods in CPU ticks
    localparam logic [8:0] DMC_NTSC_PERIODS [16] = '{
        9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
        9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84,  9'd72,  9'd54
    };
    localparam logic [8:0] DMC_PAL_PERIODS [16] = '{
        9'd398, 9'd354, 9'd316, 9'd298, 9'd276, 9'd236, 9'd210, 9'd198,
        9'd176, 9'd148, 9'd132, 9'd118, 9'd98,  9'd78,  9'd66,  9'd50
    };

    // Result word, level in the lowest bits
    typedef struct packed {
        logic [15:0] fetch_address;
        logic        fetch_request;
        logic        irq;
        logic        active;
        logic [6:0]  level;
    } dmc_result_t;

    // Start address and length of a sample run
    function automatic logic [15:0] dmc_start_addr(input logic [7:0] code);
        return DMC_ADDR_BASE | {2'b00, code, 6'b000000};
    endfunction

    function automatic logic [11:0] dmc_start_len(input logic [7:0] code);
        return {code, 4'b0001};
    endfunction

endpackage

/* rtl/dmc_core.sv */
// Channel state and configuration registers with the single-pass update
// for one word. Depends on dmc_pkg.
module dmc_core
    import dmc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [DMC_CFG_IDX_W-1:0]  cfg_index,
    input  logic [DMC_CFG_DATA_W-1:0] cfg_wdata,
    input  logic                      item_valid,
    input  logic [1:0]                item_func,
    input  logic [7:0]                item_data,
    output dmc_result_t               result
);

    // Configuration registers
    logic [3:0] rate_index_reg;
    logic       pal_mode_reg;
    logic       loop_enable_reg;
    logic       irq_enable_reg;
    logic [7:0] start_code_reg;
    logic [7:0] length_code_reg;

    // Channel state
    logic [8:0]  timer_reg,     timer_next;
    logic [7:0]  shift_reg,     shift_next;
    logic [3:0]  bits_reg,      bits_next;
    logic        silenced_reg,  silenced_next;
    logic        full_reg,      full_next;
    logic [7:0]  buffer_reg,    buffer_next;
    logic [15:0] addr_reg,      addr_next;
    logic [11:0] bytes_reg,     bytes_next;
    logic        irq_reg,       irq_next;
    logic        enabled_reg,   enabled_next;
    logic [6:0]  level_reg,     level_next;

    logic [8:0]  period;
    logic        wants_fetch;
    logic        req_next;

    assign period = pal_mode_reg ? DMC_PAL_PERIODS[rate_index_reg]
                                 : DMC_NTSC_PERIODS[rate_index_reg];
    assign wants_fetch = enabled_reg && !full_reg && (bytes_reg != 12'd0);

    // Work out the state after the word
    always_comb begin
        logic [3:0]  bits_work;
        logic        sil_work;
        logic [7:0]  shift_work;
        logic [11:0] bytes_work;

        timer_next    = timer_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        silenced_next = silenced_reg;
        full_next     = full_reg;
        buffer_next   = buffer_reg;
        addr_next     = addr_reg;
        bytes_next    = bytes_reg;
        irq_next      = irq_reg;
        enabled_next  = enabled_reg;
        level_next    = level_reg;
        bits_work     = bits_reg;
        sil_work      = silenced_reg;
        shift_work    = shift_reg;
        bytes_work    = bytes_reg - 12'd1;

        if (item_valid) begin
            case (dmc_func_t'(item_func))
                DMC_FUNC_TICK: begin
                    if (enabled_reg) begin
                        if (timer_reg != 9'd0) begin
                            timer_next = timer_reg - 9'd1;
                        end else begin
                            timer_next = period - 9'd1;
                            // start a new byte from the buffer, or go silent
                            if (bits_reg == 4'd0) begin
                                bits_work = 4'd8;
                                if (full_reg) begin
                                    sil_work   = 1'b0;
                                    full_next  = 1'b0;
                                    shift_work = buffer_reg;
                                end else begin
                                    sil_work = 1'b1;
                                end
                            end
                            silenced_next = sil_work;
                            // step the level by two, held within range
                            if (!sil_work) begin
                                if (shift_work[0]) begin
                                    if (level_reg <= 7'd125) begin
                                        level_next = level_reg + 7'd2;
                                    end
                                end else if (level_reg >= 7'd2) begin
                                    level_next = level_reg - 7'd2;
                                end
                            end
                            shift_next = shift_work >> 1;
                            bits_next  = bits_work - 4'd1;
                        end
                    end
                end
                DMC_FUNC_FETCH: begin
                    // take the byte only if one was asked for
                    if (wants_fetch) begin
                        buffer_next = item_data;
                        full_next   = 1'b1;
                        addr_next   = (addr_reg == DMC_ADDR_TOP) ? DMC_ADDR_WRAP
                                                                : addr_reg + 16'd1;
                        bytes_next  = bytes_work;
                        if (bytes_work == 12'd0) begin
                            if (loop_enable_reg) begin
                                addr_next  = dmc_start_addr(start_code_reg);
                                bytes_next = dmc_start_len(length_code_reg);
                            end else if (irq_enable_reg) begin
                                irq_next = 1'b1;
                            end
                        end
                    end
                end
                DMC_FUNC_LOAD: begin
                    level_next = item_data[6:0];
                end
                DMC_FUNC_ENABLE: begin
                    enabled_next = item_data[0];
                    irq_next     = 1'b0;
                    if (item_data[0]) begin
                        if (bytes_reg == 12'd0) begin
                            addr_next  = dmc_start_addr(start_code_reg);
                            bytes_next = dmc_start_len(length_code_reg);
                        end
                    end else begin
                        bytes_next = 12'd0;
                    end
                end
                default: begin
                end
            endcase
        end

        // clearing irq enable drops a pending interrupt
        if (cfg_wr_en && (dmc_reg_t'(cfg_index) == DMC_REG_IRQEN) && !cfg_wdata[0]) begin
            irq_next = 1'b0;
        end
    end

    // Result shows the state after the word
    assign req_next = enabled_next && !full_next && (bytes_next != 12'd0);
    always_comb begin
        result.level         = level_next;
        result.active        = (bytes_next != 12'd0);
        result.irq           = irq_next;
        result.fetch_request = req_next;
        result.fetch_address = req_next ? addr_next : 16'd0;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_index_reg  <= 4'd0;
            pal_mode_reg    <= 1'b0;
            loop_enable_reg <= 1'b0;
            irq_enable_reg  <= 1'b0;
            start_code_reg  <= 8'd0;
            length_code_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            case (dmc_reg_t'(cfg_index))
                DMC_REG_RATE:   rate_index_reg  <= cfg_wdata[3:0];
                DMC_REG_PAL:    pal_mode_reg    <= cfg_wdata[0];
                DMC_REG_LOOP:   loop_enable_reg <= cfg_wdata[0];
                DMC_REG_IRQEN:  irq_enable_reg  <= cfg_wdata[0];
                DMC_REG_START:  start_code_reg  <= cfg_wdata;
                DMC_REG_LENGTH: length_code_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Hold the channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg    <= 9'd0;
            shift_reg    <= 8'd0;
            bits_reg     <= 4'd0;
            silenced_reg <= 1'b1;
            full_reg     <= 1'b0;
            buffer_reg   <= 8'd0;
            addr_reg     <= DMC_ADDR_BASE;
            bytes_reg    <= 12'd0;
            irq_reg      <= 1'b0;
            enabled_reg  <= 1'b0;
            level_reg    <= 7'd0;
        end else begin
            timer_reg    <= timer_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            silenced_reg <= silenced_next;
            full_reg     <= full_next;
            buffer_reg   <= buffer_next;
            addr_reg     <= addr_next;
            bytes_reg    <= bytes_next;
            irq_reg      <= irq_next;
            enabled_reg  <= enabled_next;
            level_reg    <= level_next;
        end
    end

    // A disabled channel has nothing left to fetch
    a_disabled_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !enabled_reg |-> (bytes_reg == 12'd0))
        else $error("disabled channel still has bytes to fetch");

    // The bit counter never runs past one byte
    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= 4'd8)
        else $error("bit counter out of range");

    // A running timer counts down by one per enabled tick
    a_timer_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && (item_func == DMC_FUNC_TICK) && enabled_reg && (timer_reg != 9'd0))
        |=> (timer_reg == $past(timer_reg) - 9'd1))
        else $error("rate timer did not count down");

    // The interrupt only rises on an accepted byte
    a_irq_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(irq_reg) |-> $past(item_valid && (item_func == DMC_FUNC_FETCH) && wants_fetch))
        else $error("interrupt raised without a fetched byte");

endmodule

/* rtl/dmc_out_stage.sv */
// Result register on the master side with its valid flag.
// Depends on dmc_pkg.
module dmc_out_stage
    import dmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  dmc_result_t result,
    output logic        can_take,
    output logic        m_tvalid,
    input  logic        m_tready,
    output dmc_result_t m_result
);

    logic        valid_reg, valid_next;
    dmc_result_t data_reg;

    // Free when empty or being drained this cycle
    assign can_take = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result word
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

endmodule

/* rtl/delta_modulation_sample_channel_unit.sv */
// Top level of the delta-modulation sample channel: input register, channel
// core and result register. Depends on dmc_pkg, dmc_core and dmc_out_stage.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tuser[1:0] func, s_tdata[7:0] data
//  m_        out  m_tvalid/m_tready  m_tdata[25:0] level..fetch_address
//  cfg_      in   cfg_wr_en          cfg_index[2:0], cfg_wdata[7:0]
//
// One word per cycle is accepted unless the result side stalls; a word waits in
// the input register, then the core update writes the result register.
// The whole state update is one pass through the core between the two.
// aresetn is synchronous, active low; clears valid flags and core registers.
// A stall on m_tready holds the result and backs up into s_tready, which
// stays high as long as the result register is empty or draining.
module delta_modulation_sample_channel_unit
    import dmc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic [DMC_CFG_IDX_W-1:0]   cfg_index,
    input  logic [DMC_CFG_DATA_W-1:0]  cfg_wdata,
    // slave side
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data
    input  logic [1:0]                 s_tuser,   // [1:0] func
    // master side
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [6:0] level, [7] active, [8] irq, [9] fetch_request,
    // [25:10] fetch_address, [31:26] zero
    output logic [DMC_OUT_BYTES_W-1:0] m_tdata
);

    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_func_reg;
    logic [7:0]  in_data_reg;
    logic        out_can_take;
    logic        advance;
    dmc_result_t core_result;
    dmc_result_t out_result;

    assign advance  = in_valid_reg && out_can_take;
    assign s_tready = !in_valid_reg || out_can_take;

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    dmc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (advance),
        .item_func  (in_func_reg),
        .item_data  (in_data_reg),
        .result     (core_result)
    );

    dmc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (core_result),
        .can_take (out_can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (out_result)
    );

    // Pad the result word to whole bytes
    assign m_tdata = {{(DMC_OUT_BYTES_W - DMC_OUT_W){1'b0}}, out_result};

endmodule

/* bench/delta_modulation_sample_channel_unit_checker.sv */
// Checker for the delta-modulation sample channel: follows the config port and
// both stream channels, predicts each result word and compares it field by field.
// Depends on dmc_pkg.
`timescale 1ns / 100ps

module delta_modulation_sample_channel_unit_checker
    import dmc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [DMC_CFG_IDX_W-1:0]   cfg_index,
    input  logic [DMC_CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data
    input  logic [1:0]                 s_tuser,   // [1:0] func
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    // [6:0] level, [7] active, [8] irq, [9] fetch_request, [25:10] fetch_address
    input  logic [DMC_OUT_BYTES_W-1:0] m_tdata,
    output int                         mismatches,
    output int                         results_owed,
    output logic                       byte_due
);

    // Bit periods in CPU ticks
    localparam logic [8:0] RATE_TICKS_NTSC [16] = '{
        9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
        9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84,  9'd72,  9'd54
    };
    localparam logic [8:0] RATE_TICKS_PAL [16] = '{
        9'd398, 9'd354, 9'd316, 9'd298, 9'd276, 9'd236, 9'd210, 9'd198,
        9'd176, 9'd148, 9'd132, 9'd118, 9'd98,  9'd78,  9'd66,  9'd50
    };

    // Register copies
    logic [3:0]  rate_sel;
    logic        pal_sel;
    logic        loop_on;
    logic        irq_on;
    logic [7:0]  start_code;
    logic [7:0]  len_code;

    // Channel state
    logic [8:0]  bit_timer;
    logic [7:0]  shifter;
    logic [3:0]  bits_left;
    logic        muted;
    logic        buf_full;
    logic [7:0]  buf_byte;
    logic [15:0] addr;
    logic [11:0] bytes_left;
    logic        irq_pend;
    logic        chan_on;
    logic [6:0]  lvl;

    dmc_result_t predicted_outputs [$];

    initial begin
        mismatches   = 0;
        results_owed = 0;
        byte_due     = 1'b0;
    end

    function automatic void clear_channel();
        rate_sel   = '0;
        pal_sel    = 1'b0;
        loop_on    = 1'b0;
        irq_on     = 1'b0;
        start_code = '0;
        len_code   = '0;
        bit_timer  = '0;
        shifter    = '0;
        bits_left  = '0;
        muted      = 1'b1;
        buf_full   = 1'b0;
        buf_byte   = '0;
        addr       = DMC_ADDR_BASE;
        bytes_left = '0;
        irq_pend   = 1'b0;
        chan_on    = 1'b0;
        lvl        = '0;
    endfunction

    function automatic logic wants_byte();
        return chan_on && !buf_full && (bytes_left != 12'd0);
    endfunction

    // Rewind to the first byte of the sample
    function automatic void restart_sample();
        addr       = 16'hC000 | {2'b00, start_code, 6'b000000};
        bytes_left = {len_code, 4'b0001};
    endfunction

    function automatic void write_register(dmc_reg_t idx, logic [7:0] value);
        case (idx)
            DMC_REG_RATE:   rate_sel   = value[3:0];
            DMC_REG_PAL:    pal_sel    = value[0];
            DMC_REG_LOOP:   loop_on    = value[0];
            DMC_REG_IRQEN: begin
                irq_on = value[0];
                if (!irq_on)
                    irq_pend = 1'b0;
            end
            DMC_REG_START:  start_code = value;
            DMC_REG_LENGTH: len_code   = value;
            default: ;
        endcase
    endfunction

    // One CPU tick: count down, or on expiry shift out one bit and step the level
    function automatic void run_tick();
        if (!chan_on)
            return;
        if (bit_timer != 9'd0) begin
            bit_timer = bit_timer - 9'd1;
            return;
        end
        bit_timer = (pal_sel ? RATE_TICKS_PAL[rate_sel] : RATE_TICKS_NTSC[rate_sel]) - 9'd1;
        if (bits_left == 4'd0) begin
            bits_left = 4'd8;
            if (buf_full) begin
                muted    = 1'b0;
                buf_full = 1'b0;
                shifter  = buf_byte;
            end else begin
                muted = 1'b1;
            end
        end
        if (!muted) begin
            if (shifter[0]) begin
                if (lvl <= 7'd125)
                    lvl = lvl + 7'd2;
            end else if (lvl >= 7'd2) begin
                lvl = lvl - 7'd2;
            end
        end
        shifter   = shifter >> 1;
        bits_left = bits_left - 4'd1;
    endfunction

    // Take a fetched byte only while one is requested
    function automatic void take_byte(logic [7:0] value);
        if (!wants_byte())
            return;
        buf_byte   = value;
        buf_full   = 1'b1;
        addr       = (addr == DMC_ADDR_TOP) ? DMC_ADDR_WRAP : addr + 16'd1;
        bytes_left = bytes_left - 12'd1;
        if (bytes_left == 12'd0) begin
            if (loop_on)
                restart_sample();
            else if (irq_on)
                irq_pend = 1'b1;
        end
    endfunction

    function automatic dmc_result_t next_channel_word(dmc_func_t kind, logic [7:0] value);
        dmc_result_t word;
        case (kind)
            DMC_FUNC_TICK:  run_tick();
            DMC_FUNC_FETCH: take_byte(value);
            DMC_FUNC_LOAD:  lvl = value[6:0];
            default: begin
                chan_on  = value[0];
                irq_pend = 1'b0;
                if (!chan_on)
                    bytes_left = 12'd0;
                else if (bytes_left == 12'd0)
                    restart_sample();
            end
        endcase
        word.level         = lvl;
        word.active        = (bytes_left != 12'd0);
        word.irq           = irq_pend;
        word.fetch_request = wants_byte();
        word.fetch_address = wants_byte() ? addr : 16'h0000;
        return word;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Apply writes, retire results, then predict the newly accepted word
    always @(posedge aclk) begin
        dmc_result_t want;
        dmc_result_t got;
        if (!aresetn) begin
            clear_channel();
            predicted_outputs.delete();
            results_owed <= 0;
            byte_due     <= 1'b0;
        end else begin
            if (cfg_wr_en)
                write_register(dmc_reg_t'(cfg_index), cfg_wdata);
            if (m_tvalid && m_tready) begin
                got = dmc_result_t'(m_tdata[DMC_OUT_W-1:0]);
                if (predicted_outputs.size() == 0) begin
                    $display("%0t ns: result word with none expected, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("level", want.level, got.level);
                    check_field("active", want.active, got.active);
                    check_field("irq", want.irq, got.irq);
                    check_field("fetch_request", want.fetch_request, got.fetch_request);
                    check_field("fetch_address", want.fetch_address, got.fetch_address);
                    check_field("padding", 0, m_tdata[DMC_OUT_BYTES_W-1:DMC_OUT_W]);
                end
            end
            if (s_tvalid && s_tready)
                predicted_outputs.push_back(next_channel_word(dmc_func_t'(s_tuser), s_tdata));
            results_owed <= predicted_outputs.size();
            byte_due     <= wants_byte();
        end
    end

endmodule

/* bench/delta_modulation_sample_channel_unit_tb.sv */
// Testbench top for the delta-modulation sample channel: clock, reset, stimulus,
// result-side back-pressure and the verdict.
// Depends on dmc_pkg, the channel RTL and delta_modulation_sample_channel_unit_checker.
`timescale 1ns / 100ps

module delta_modulation_sample_channel_unit_tb;
    import dmc_pkg::*;

    localparam int HOLD_CYCLES = 64;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [DMC_CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DMC_CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata   = '0;   // [7:0] data
    logic [1:0]                 s_tuser   = '0;   // [1:0] func
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    // [6:0] level, [7] active, [8] irq, [9] fetch_request, [25:10] fetch_address
    logic [DMC_OUT_BYTES_W-1:0] m_tdata;

    int   mismatches;
    int   results_owed;
    logic byte_due;

    int   tx_idle_pct   = 31;
    int   rx_idle_pct   = 31;
    int   hold_req      = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    logic last_was_fetch = 1'b0;

    delta_modulation_sample_channel_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    delta_modulation_sample_channel_unit_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .results_owed (results_owed),
        .byte_due     (byte_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("delta_modulation_sample_channel_unit_tb failed");
        $finish;
    end

    // Offer one word, with random gaps ahead of it, and hold it until taken
    task automatic send_word(input dmc_func_t kind, input logic [7:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        last_was_fetch = (kind == DMC_FUNC_FETCH);
    endtask

    // Stop offering and wait for every predicted word to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input dmc_reg_t idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [3:0] rate, input logic pal, input logic loop_on,
                                input logic irq_on, input logic [7:0] start_code,
                                input logic [7:0] len_code);
        write_reg(DMC_REG_RATE,   {4'd0, rate});
        write_reg(DMC_REG_PAL,    {7'd0, pal});
        write_reg(DMC_REG_LOOP,   {7'd0, loop_on});
        write_reg(DMC_REG_IRQEN,  {7'd0, irq_on});
        write_reg(DMC_REG_START,  start_code);
        write_reg(DMC_REG_LENGTH, len_code);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly ticks, bytes when asked for, some stray bytes, loads and enables
    task automatic random_word();
        int          pick;
        logic [7:0]  value;
        pick  = $urandom_range(99);
        value = 8'($urandom);
        if (byte_due && !last_was_fetch && pick < 60) begin
            send_word(DMC_FUNC_FETCH, value);
        end else if (pick < 75) begin
            send_word(DMC_FUNC_TICK, value);
        end else if (pick < 83) begin
            send_word(DMC_FUNC_FETCH, value);
        end else if (pick < 92) begin
            if ($urandom_range(1) == 1) begin
                case ($urandom_range(3))
                    0: value[6:0] = 7'd0;
                    1: value[6:0] = 7'd1;
                    2: value[6:0] = 7'd126;
                    default: value[6:0] = 7'd127;
                endcase
            end
            send_word(DMC_FUNC_LOAD, value);
        end else begin
            value[0] = ($urandom_range(99) < 75);
            send_word(DMC_FUNC_ENABLE, value);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one-byte sample at the top of the address space, irq on
        program_regs(4'd15, 1'b0, 1'b0, 1'b1, 8'd255, 8'd0);
        send_word(DMC_FUNC_TICK,   8'hFF);  // disabled tick does nothing
        send_word(DMC_FUNC_FETCH,  8'hAA);  // byte nobody asked for
        send_word(DMC_FUNC_LOAD,   8'hFE);  // level 126, top bit dropped
        send_word(DMC_FUNC_ENABLE, 8'h01);  // start the sample
        send_word(DMC_FUNC_FETCH,  8'hFF);  // last byte: raises irq
        send_word(DMC_FUNC_TICK,   8'h00);  // first bit up, held at the ceiling
        send_word(DMC_FUNC_LOAD,   8'h7F);
        send_word(DMC_FUNC_TICK,   8'h5A);
        send_word(DMC_FUNC_ENABLE, 8'h03);  // clears irq, restarts
        send_word(DMC_FUNC_FETCH,  8'h00);
        send_word(DMC_FUNC_LOAD,   8'h81);
        send_word(DMC_FUNC_ENABLE, 8'h00);  // disable drops the remaining bytes
        send_word(DMC_FUNC_FETCH,  8'h12);
        send_word(DMC_FUNC_TICK,   8'h33);
        send_word(DMC_FUNC_ENABLE, 8'hFE);  // only bit 0 counts
        send_word(DMC_FUNC_ENABLE, 8'h81);
        send_word(DMC_FUNC_LOAD,   8'h80);
        drain();

        // Stretch without gaps on either side, fast PAL timing, 65-byte sample
        program_regs(4'd15, 1'b1, 1'b0, 1'b1, 8'd255, 8'd4);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        send_word(DMC_FUNC_ENABLE, 8'h00);
        send_word(DMC_FUNC_ENABLE, 8'h01);
        repeat (100) random_word();
        drain();
        rx_idle_pct <= 31;

        // Random phases, each under its own register setting
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: program_regs(4'd0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0);
                1: program_regs(4'd15, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255);
                2: program_regs(4'd14, 1'b0, 1'b0, 1'b1, 8'($urandom), 8'd0);
                default: program_regs(($urandom_range(99) < 70) ? 4'($urandom_range(15, 12))
                                                                : 4'($urandom_range(15)),
                                      1'($urandom), 1'($urandom), 1'($urandom),
                                      8'($urandom), 8'($urandom_range(3)));
            endcase
            // Back up the block: receiver holds off while words keep coming
            tx_idle_pct = (phase == 3) ? 0 : 31;
            if (phase == 3)
                hold_req <= hold_req + 1;
            repeat (38) random_word();
            drain();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("delta_modulation_sample_channel_unit_tb passed");
        end else begin
            $display("delta_modulation_sample_channel_unit_tb failed");
        end
        $finish;
    end

endmodule
